// ----- hw/rtl/grl_pkg.sv -----
// ----------------------------------------------------------------------------
// grl_pkg: shared types and constants of the glyph range lookup block
// Holds the table entry layout, the table access requests, the result
// record and the codes that more than one file uses.
// ----------------------------------------------------------------------------
package grl_pkg;

  localparam int DefMaxRanges = 1024;
  localparam int DefAddrBits  = 24;

  localparam int CountW   = 11;  // range_count register width
  localparam int IndexW   = 10;  // entry_index and range_index field width
  localparam int CpW      = 21;  // code point width
  localparam int BoundW   = 16;
  localparam int WidthW   = 8;
  localparam int OffsetW  = 24;
  localparam int GlyphAW  = 24;  // glyph_address field width
  localparam int RowsLog2 = 4;   // sixteen rows per glyph
  localparam int ProdW    = BoundW + WidthW;
  localparam int FullW    = ProdW + RowsLog2 + 1;
  localparam int TblAddrW = 16;  // covers the largest table depth

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // Word address bit of the configuration port.
  localparam logic REG_RANGE_COUNT = 1'b0;

  typedef struct packed {
    logic [BoundW-1:0]  low;
    logic [BoundW-1:0]  high;
    logic [WidthW-1:0]  width;
    logic [OffsetW-1:0] offset;
  } entry_t;

  typedef struct packed {
    logic                en;
    logic [TblAddrW-1:0] addr;
    entry_t              data;
  } tbl_wr_t;

  typedef struct packed {
    logic                en;
    logic [TblAddrW-1:0] addr;
  } tbl_rd_t;

  typedef struct packed {
    logic               address_overflow;
    logic [GlyphAW-1:0] glyph_address;
    logic [WidthW-1:0]  glyph_width;
    logic [IndexW-1:0]  range_index;
    logic               found;
  } result_t;

endpackage

// ----- hw/rtl/grl_table.sv -----
// ----------------------------------------------------------------------------
// grl_table: range table memory
// One synchronous memory of range entries with one write port and one read
// port; read data is registered and appears in the cycle after the request.
// ----------------------------------------------------------------------------
module grl_table #(
  parameter int MaxRanges = grl_pkg::DefMaxRanges
) (
  input  logic             clk_i,
  input  grl_pkg::tbl_wr_t wr_i,
  input  grl_pkg::tbl_rd_t rd_i,
  output grl_pkg::entry_t  rdata_o
);
  import grl_pkg::*;

  localparam int IdxW = (MaxRanges > 1) ? $clog2(MaxRanges) : 1;

  entry_t mem [MaxRanges];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr[IdxW-1:0]] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[rd_i.addr[IdxW-1:0]];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/grl_search.sv -----
// ----------------------------------------------------------------------------
// grl_search: binary search sequencer and glyph address unit
// Walks the range table one probe per cycle, then forms the glyph address
// with a registered multiply and a combinational add.
// ----------------------------------------------------------------------------
module grl_search #(
  parameter int MaxRanges = grl_pkg::DefMaxRanges,
  parameter int AddrBits  = grl_pkg::DefAddrBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [grl_pkg::CpW-1:0]      cp_i,
  input  logic [grl_pkg::CountW-1:0]   count_i,
  output logic                         idle_o,
  output grl_pkg::tbl_rd_t             rd_o,
  input  grl_pkg::entry_t              rdata_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output grl_pkg::result_t             res_o
);
  import grl_pkg::*;

  localparam int CntW = $clog2(MaxRanges + 1);
  localparam logic [32:0] AddrMask = (33'd1 << AddrBits) - 33'd1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]         state_q, state_d;
  logic [CntW-1:0]    lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic               miss_q, miss_d;
  logic [CpW-1:0]     cp_q;
  logic [BoundW-1:0]  rel_q, rel_d;
  logic [WidthW-1:0]  width_q, width_d;
  logic [OffsetW-1:0] offset_q, offset_d;
  logic [ProdW-1:0]   prod_q;

  logic [31:0]        cnt32, nsat32, mid32;
  logic [CntW-1:0]    n_c, lo_n, hi_n;
  logic [CntW:0]      span;
  logic               lt, gt;
  logic [FullW-1:0]   full;
  logic [32:0]        full33;

  assign cnt32  = 32'(count_i);
  assign nsat32 = (cnt32 > 32'(MaxRanges)) ? 32'(MaxRanges) : cnt32;
  assign n_c    = nsat32[CntW-1:0];

  assign lt = {{(CpW-BoundW){1'b0}}, rdata_i.low} > cp_q;
  assign gt = cp_q > {{(CpW-BoundW){1'b0}}, rdata_i.high};
  assign lo_n = (!lt && gt) ? (mid_q + CntW'(1)) : lo_q;
  assign hi_n = lt ? mid_q : hi_q;
  assign span = {1'b0, lo_n} + {1'b0, hi_n} - (CntW+1)'(1);

  always_comb begin
    state_d  = state_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    mid_d    = mid_q;
    miss_d   = miss_q;
    rel_d    = rel_q;
    width_d  = width_q;
    offset_d = offset_q;
    rd_o     = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          lo_d = '0;
          hi_d = n_c;
          if (n_c == '0) begin
            miss_d  = 1'b1;
            state_d = S_FIN;
          end else begin
            mid_d   = (n_c - CntW'(1)) >> 1;
            rd_o.en = 1'b1;
            rd_o.addr = TblAddrW'(mid_d);
            state_d = S_CMP;
          end
        end
      end
      S_CMP: begin
        if (!lt && !gt) begin
          rel_d    = cp_q[BoundW-1:0] - rdata_i.low;
          width_d  = rdata_i.width;
          offset_d = rdata_i.offset;
          miss_d   = 1'b0;
          state_d  = S_MUL;
        end else begin
          lo_d = lo_n;
          hi_d = hi_n;
          if (lo_n < hi_n) begin
            mid_d     = span[CntW:1];
            rd_o.en   = 1'b1;
            rd_o.addr = TblAddrW'(mid_d);
          end else begin
            miss_d  = 1'b1;
            state_d = S_FIN;
          end
        end
      end
      S_MUL: begin
        state_d = S_FIN;
      end
      S_FIN: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    miss_q   <= miss_d;
    rel_q    <= rel_d;
    width_q  <= width_d;
    offset_q <= offset_d;
    if (state_q == S_IDLE && start_i) begin
      cp_q <= cp_i;
    end
    if (state_q == S_MUL) begin
      prod_q <= rel_q * width_q;
    end
  end

  // Address adder: offset plus product scaled by the sixteen rows of a glyph.
  assign full   = FullW'(offset_q) + FullW'({prod_q, {RowsLog2{1'b0}}});
  assign full33 = 33'(full);
  assign mid32  = 32'(mid_q);

  always_comb begin
    res_o = '0;
    if (!miss_q) begin
      res_o.found            = 1'b1;
      res_o.range_index      = mid32[IndexW-1:0];
      res_o.glyph_width      = width_q;
      res_o.glyph_address    = GlyphAW'(full33 & AddrMask);
      res_o.address_overflow = |(full33 & ~AddrMask);
    end
  end

  assign res_valid_o = (state_q == S_FIN);
  assign idle_o      = (state_q == S_IDLE);

endmodule

// ----- hw/rtl/glyph_range_lookup_core.sv -----
// ----------------------------------------------------------------------------
// glyph_range_lookup_core: code point to glyph bitmap address lookup
// Loads a sorted table of code-point ranges and binary-searches it to find
// the byte address of a glyph bitmap.
// ----------------------------------------------------------------------------
// A load request (tuser = 0) writes one range entry into the table and
// returns nothing; a slot at or beyond MaxRanges is dropped.
// A lookup request (tuser = 1) searches the first range_count entries
// (clipped to MaxRanges) and returns one result: the found flag, the entry
// index, the row width and offset + (codepoint - low) * width * 16, cut to
// AddrBits bits with address_overflow set when the full address did not fit.
// A miss returns all zeros. A lookup passes an accept step, the table
// probes at one probe per cycle (at most ceil(log2(range_count + 1)), eleven
// for 1024 entries), a registered multiply and a hand-off to the output
// register; the table memory has a single read port. The search unit holds
// one request at a time; a finished result waits in the output register
// while the next request is taken. Table contents are undefined after
// reset and must be loaded before they are searched. range_count is written
// over the APB port at byte address 0 and should only change while no
// lookup is in flight.
// ----------------------------------------------------------------------------
module glyph_range_lookup_core #(
  parameter int MaxRanges = grl_pkg::DefMaxRanges,
  parameter int AddrBits  = grl_pkg::DefAddrBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // entry_index[9:0], range_low[25:10], range_high[41:26], entry_width[49:42],
  // entry_offset[73:50], codepoint[94:74], zero pad[95]
  input  logic [95:0] s_axis_tdata,
  // op[0]
  input  logic        s_axis_tuser,
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // found[0], range_index[10:1], glyph_width[18:11], glyph_address[42:19],
  // address_overflow[43], zero pad[47:44]
  output logic [47:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import grl_pkg::*;

  logic [CountW-1:0] range_count_q;
  logic              reg_sel;

  logic              in_fire;
  logic [31:0]       slot32;
  tbl_wr_t           tbl_wr;
  tbl_rd_t           tbl_rd;
  entry_t            tbl_rdata;

  logic              srch_idle;
  logic              res_valid, res_ready;
  result_t           res;

  logic              out_valid_q;
  result_t           out_data_q;

  // Configuration registers: one word register, the byte offset is ignored.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_RANGE_COUNT);
  assign prdata  = reg_sel ? 32'(range_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_count_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      range_count_q <= pwdata[CountW-1:0];
    end
  end

  // Requests are taken only while the search unit is idle, so a load never
  // overlaps a table read and needs no forwarding.
  assign s_axis_tready = srch_idle;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign slot32        = 32'(s_axis_tdata[9:0]);

  always_comb begin
    tbl_wr             = '0;
    tbl_wr.en          = in_fire && (s_axis_tuser == OP_LOAD) &&
                         (slot32 < 32'(MaxRanges));
    tbl_wr.addr        = slot32[TblAddrW-1:0];
    tbl_wr.data.low    = s_axis_tdata[25:10];
    tbl_wr.data.high   = s_axis_tdata[41:26];
    tbl_wr.data.width  = s_axis_tdata[49:42];
    tbl_wr.data.offset = s_axis_tdata[73:50];
  end

  grl_table #(
    .MaxRanges(MaxRanges)
  ) u_table (
    .clk_i  (clk_i),
    .wr_i   (tbl_wr),
    .rd_i   (tbl_rd),
    .rdata_o(tbl_rdata)
  );

  grl_search #(
    .MaxRanges(MaxRanges),
    .AddrBits (AddrBits)
  ) u_search (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire && (s_axis_tuser == OP_LOOKUP)),
    .cp_i       (s_axis_tdata[94:74]),
    .count_i    (range_count_q),
    .idle_o     (srch_idle),
    .rd_o       (tbl_rd),
    .rdata_i    (tbl_rdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_ready),
    .res_o      (res)
  );

  // Output register: frees the search unit as soon as a result is parked.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_data_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_data_q};

endmodule
